// ===== sv/rgrls_pkg.sv =====
// Shared widths, reset values, register map and sequencer states of the rate gain estimator.
package rgrls_pkg;

	localparam int RATE_W   = 16;
	localparam int LAMBDA_W = 16;
	localparam int INVP_W   = 14;
	localparam int THR_W    = 40;
	localparam int EST_W    = 16;
	localparam int FRAC_W   = 8;
	localparam int PROD_W   = 2 * (RATE_W + 1) + INVP_W;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;

	localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd65339;
	localparam logic [INVP_W-1:0]   INVP_RESET   = 14'd100;
	localparam logic [THR_W-1:0]    THR_RESET    = 40'd10486;
	localparam logic [EST_W-1:0]    EST_MIN_RESET = 16'd256;
	localparam logic [EST_W-1:0]    EST_MAX_RESET = 16'd51200;
	localparam logic [EST_W-1:0]    EST_RESET     = 16'd8533;

	localparam logic [2:0] REG_LAMBDA  = 3'd0;
	localparam logic [2:0] REG_INVP    = 3'd1;
	localparam logic [2:0] REG_THR     = 3'd2;
	localparam logic [2:0] REG_EST_MIN = 3'd3;
	localparam logic [2:0] REG_EST_MAX = 3'd4;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DIFF  = 10'b0000000010,
		S_MUL1  = 10'b0000000100,
		S_MUL2  = 10'b0000001000,
		S_RND   = 10'b0000010000,
		S_ACC   = 10'b0000100000,
		S_CMP   = 10'b0001000000,
		S_DIV   = 10'b0010000000,
		S_CLAMP = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

endpackage

// ===== sv/rate_gain_rls_estimator_core.sv =====
// Top level of the rate-loop gain estimator: register port, sequencer and accumulators.
// Pacing: a new item is taken only in the idle state, after the last result is loaded; set by the two-bit-per-cycle
//   multipliers (7 + 9 digit steps per axis) and the one-bit-per-cycle 16-step divider.
// Reset: clears the sequencer, output valid, the config registers to their defaults, the previous
//   rates, numerator (0), denominator (1) and estimate (8533).
module rate_gain_rls_estimator_core
	import rgrls_pkg::*;
#(
	parameter int AXIS_COUNT        = 3,
	parameter int ACCUMULATOR_WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [RATE_W-1:0] rate_x,
	input  logic signed [RATE_W-1:0] rate_y,
	input  logic signed [RATE_W-1:0] rate_z,
	input  logic signed [RATE_W-1:0] command_x,
	input  logic signed [RATE_W-1:0] command_y,
	input  logic signed [RATE_W-1:0] command_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [EST_W-1:0]         gain_estimate,
	output logic                     estimate_updated
);

	localparam int W   = ACCUMULATOR_WIDTH;
	localparam int SW  = ((W > PROD_W) ? W : PROD_W) + 1;
	localparam int AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int DW  = RATE_W + 1 + INVP_W;
	localparam int QW  = 2 * (RATE_W + 1);

	// saturation bounds of the signed numerator, at the width of the sum
	localparam logic signed [SW-1:0] NUM_MAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] NUM_MIN_S = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

	// configuration registers
	logic [LAMBDA_W-1:0] lam_q;
	logic [INVP_W-1:0]   invp_q;
	logic [THR_W-1:0]    thr_q;
	logic [EST_W-1:0]    min_q;
	logic [EST_W-1:0]    max_q;
	logic                cfg_wr;

	// sequencer and estimator state
	state_t                   state_q;
	state_t                   state_d;
	logic [AXW-1:0]           ax_q;
	logic signed [RATE_W-1:0] rate_q [AXIS_COUNT];
	logic signed [RATE_W-1:0] cmd_q  [AXIS_COUNT];
	logic signed [RATE_W-1:0] prev_q [AXIS_COUNT];
	logic signed [W-1:0]      num_q;
	logic [W-1:0]             den_q;
	logic [EST_W-1:0]         est_q;
	logic                     upd_q;
	logic                     out_valid_q;
	logic [EST_W-1:0]         gain_q;
	logic                     updated_q;

	// per-axis working registers
	logic [RATE_W:0]          err_mag_q;
	logic                     diff_neg_q;
	logic                     err_neg_q;
	logic                     num_neg_q;
	logic signed [W-1:0]      sn_q;
	logic [W-1:0]             sd_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     pos_q;

	// combinational datapath
	logic [RATE_W:0]          diff_w;
	logic [RATE_W:0]          err_w;
	logic [RATE_W:0]          diff_mag_w;
	logic [RATE_W:0]          err_mag_w;
	logic [W-1:0]             num_mag_w;
	logic [DW-1:0]            deriv_mag_w;
	logic [QW-1:0]            sq_w;
	logic [PROD_W-1:0]        prod_mag_w;
	logic [W+LAMBDA_W-1:0]    nscl_w;
	logic [W+LAMBDA_W-1:0]    dscl_w;
	logic [W+1:0]             nrnd_w;
	logic [W+1:0]             drnd_w;
	logic signed [SW-1:0]     nsum_w;
	logic [W:0]               dsum_w;
	logic signed [W-1:0]      num_next;
	logic [W-1:0]             den_next;
	logic                     den_gt;
	logic                     pos_w;
	logic [EST_W:0]           quo_w;
	logic [EST_W:0]           val_w;
	logic [EST_W-1:0]         clamp_w;
	logic                     out_free;

	// unit handshakes
	logic st_diff;
	logic st_prod;
	logic div_start;
	logic deriv_busy;
	logic sq_busy;
	logic prod_busy;
	logic nscl_busy;
	logic dscl_busy;
	logic div_busy;

	// ---------------------------------------------------------------- register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		case (paddr[5:3])
			REG_LAMBDA:  prdata = DATA_W'(lam_q);
			REG_INVP:    prdata = DATA_W'(invp_q);
			REG_THR:     prdata = DATA_W'(thr_q);
			REG_EST_MIN: prdata = DATA_W'(min_q);
			REG_EST_MAX: prdata = DATA_W'(max_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q  <= LAMBDA_RESET;
			invp_q <= INVP_RESET;
			thr_q  <= THR_RESET;
			min_q  <= EST_MIN_RESET;
			max_q  <= EST_MAX_RESET;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_LAMBDA:  lam_q  <= pwdata[LAMBDA_W-1:0];
				REG_INVP:    invp_q <= pwdata[INVP_W-1:0];
				REG_THR:     thr_q  <= pwdata[THR_W-1:0];
				REG_EST_MIN: min_q  <= pwdata[EST_W-1:0];
				REG_EST_MAX: max_q  <= pwdata[EST_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- axis front end
	// The current axis always sits at index 0; the arrays rotate after each axis.
	assign diff_w     = {rate_q[0][RATE_W-1], rate_q[0]} - {prev_q[0][RATE_W-1], prev_q[0]};
	assign err_w      = {cmd_q[0][RATE_W-1], cmd_q[0]} - {prev_q[0][RATE_W-1], prev_q[0]};
	assign diff_mag_w = diff_w[RATE_W] ? -diff_w : diff_w;
	assign err_mag_w  = err_w[RATE_W] ? -err_w : err_w;
	assign num_mag_w  = num_q[W-1] ? W'(-num_q) : W'(num_q);

	// deriv = |rate - prev| * inverse_period, err^2, and the two forgetting scalings run together;
	// deriv * err starts once deriv is ready.
	rgrls_serial_mult #(.A_W(RATE_W + 1), .B_W(INVP_W)) u_deriv (
		.clk(clk), .arst_n(arst_n), .start(st_diff), .a(diff_mag_w), .b(invp_q),
		.busy(deriv_busy), .p(deriv_mag_w)
	);

	rgrls_serial_mult #(.A_W(RATE_W + 1), .B_W(RATE_W + 1)) u_sq (
		.clk(clk), .arst_n(arst_n), .start(st_diff), .a(err_mag_w), .b(err_mag_w),
		.busy(sq_busy), .p(sq_w)
	);

	rgrls_serial_mult #(.A_W(DW), .B_W(RATE_W + 1)) u_prod (
		.clk(clk), .arst_n(arst_n), .start(st_prod), .a(deriv_mag_w), .b(err_mag_q),
		.busy(prod_busy), .p(prod_mag_w)
	);

	rgrls_serial_mult #(.A_W(W), .B_W(LAMBDA_W)) u_nscl (
		.clk(clk), .arst_n(arst_n), .start(st_diff), .a(num_mag_w), .b(lam_q),
		.busy(nscl_busy), .p(nscl_w)
	);

	rgrls_serial_mult #(.A_W(W), .B_W(LAMBDA_W)) u_dscl (
		.clk(clk), .arst_n(arst_n), .start(st_diff), .a(den_q), .b(lam_q),
		.busy(dscl_busy), .p(dscl_w)
	);

	// round lambda*m to nearest, lambda at Q.16: (P + 2^15) >> 16
	assign nrnd_w = {1'b0, nscl_w[W+LAMBDA_W-1:LAMBDA_W-1]} + (W+2)'(1);
	assign drnd_w = {1'b0, dscl_w[W+LAMBDA_W-1:LAMBDA_W-1]} + (W+2)'(1);

	// ---------------------------------------------------------------- accumulate and saturate
	assign nsum_w = SW'(sn_q) + SW'(prod_q);
	assign dsum_w = {1'b0, sd_q} + (W+1)'(sq_w);

	always_comb begin
		if (nsum_w > NUM_MAX_S) begin
			num_next = NUM_MAX_S[W-1:0];
		end else if (nsum_w < NUM_MIN_S) begin
			num_next = NUM_MIN_S[W-1:0];
		end else begin
			num_next = nsum_w[W-1:0];
		end
	end

	assign den_next = dsum_w[W] ? {W{1'b1}} : dsum_w[W-1:0];

	// ---------------------------------------------------------------- estimate
	assign den_gt = den_q > W'(thr_q);
	assign pos_w  = !num_q[W-1] && (num_q != '0);

	rgrls_serial_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_q), .den(den_q),
		.busy(div_busy), .quo(quo_w)
	);

	// the minimum is tested first; when the two cross, values under it take the minimum, all others the maximum
	assign val_w = pos_q ? quo_w : '0;

	always_comb begin
		if (val_w < {1'b0, min_q}) begin
			clamp_w = min_q;
		end else if (val_w > {1'b0, max_q}) begin
			clamp_w = max_q;
		end else begin
			clamp_w = val_w[EST_W-1:0];
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign out_free  = !out_valid_q || !out_stall;
	assign st_diff   = (state_q == S_DIFF);
	assign st_prod   = (state_q == S_MUL1) && !deriv_busy;
	assign div_start = (state_q == S_CMP) && den_gt && pos_w;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_DIFF;
			S_DIFF:  state_d = S_MUL1;
			S_MUL1:  if (!deriv_busy) state_d = S_MUL2;
			S_MUL2: begin
				if (!(prod_busy || sq_busy || nscl_busy || dscl_busy)) begin
					state_d = S_RND;
				end
			end
			S_RND:   state_d = S_ACC;
			S_ACC:   state_d = (ax_q == AXW'(AXIS_COUNT - 1)) ? S_CMP : S_DIFF;
			S_CMP: begin
				if (!den_gt) begin
					state_d = S_OUT;
				end else if (pos_w) begin
					state_d = S_DIV;
				end else begin
					state_d = S_CLAMP;
				end
			end
			S_DIV:   if (!div_busy) state_d = S_CLAMP;
			S_CLAMP: state_d = S_OUT;
			S_OUT:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// control and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= '0;
			out_valid_q <= 1'b0;
			num_q       <= '0;
			den_q       <= W'(1);
			est_q       <= EST_RESET;
			for (int k = 0; k < AXIS_COUNT; k++) begin
				prev_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					ax_q <= '0;
				end
				S_ACC: begin
					// commit this axis and rotate the next one to the front
					num_q <= num_next;
					den_q <= den_next;
					ax_q  <= ax_q + AXW'(1);
					for (int k = 0; k < AXIS_COUNT - 1; k++) begin
						prev_q[k] <= prev_q[k+1];
					end
					prev_q[AXIS_COUNT-1] <= rate_q[0];
				end
				S_CLAMP: begin
					est_q <= clamp_w;
				end
				default: ;
			endcase
			// hold the result until the far side takes it; load a new one when the slot is free
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					for (int k = 0; k < AXIS_COUNT; k++) begin
						rate_q[k] <= (k == 0) ? rate_x : ((k == 1) ? rate_y : rate_z);
						cmd_q[k]  <= (k == 0) ? command_x : ((k == 1) ? command_y : command_z);
					end
				end
			end
			S_DIFF: begin
				err_mag_q  <= err_mag_w;
				diff_neg_q <= diff_w[RATE_W];
				err_neg_q  <= err_w[RATE_W];
				num_neg_q  <= num_q[W-1];
			end
			S_RND: begin
				sn_q   <= num_neg_q ? -$signed(nrnd_w[W:1]) : $signed(nrnd_w[W:1]);
				sd_q   <= drnd_w[W:1];
				prod_q <= (diff_neg_q ^ err_neg_q) ? -$signed(prod_mag_w) : $signed(prod_mag_w);
			end
			S_ACC: begin
				for (int k = 0; k < AXIS_COUNT - 1; k++) begin
					rate_q[k] <= rate_q[k+1];
					cmd_q[k]  <= cmd_q[k+1];
				end
			end
			S_CMP: begin
				pos_q <= pos_w;
				upd_q <= den_gt;
			end
			S_OUT: begin
				if (out_free) begin
					gain_q    <= est_q;
					updated_q <= upd_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign gain_estimate    = gain_q;
	assign estimate_updated = updated_q;

	// ---------------------------------------------------------------- checks
	// every serial multiplier must be finished before its product is rounded and accumulated
	a_units_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RND) |-> !(deriv_busy || sq_busy || prod_busy || nscl_busy || dscl_busy))
		else $error("serial unit still busy at rounding");

	// a transfer on the input side always starts the first axis
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DIFF) && (ax_q == '0))
		else $error("input transfer did not start axis processing");

	// a new result only appears after the output step of the sequencer
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");

	// a recomputed estimate respects the clamp window when the window is well formed
	a_est_window: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && updated_q && (min_q <= max_q)) |->
		((gain_q >= min_q) && (gain_q <= max_q)))
		else $error("updated estimate outside the clamp window");

endmodule

// ===== sv/rgrls_serial_mult.sv =====
// Unsigned shift-add multiplier that consumes the multiplier two bits per cycle.
module rgrls_serial_mult #(
	parameter int A_W = 16,
	parameter int B_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic [A_W+B_W-1:0] p
);

	localparam int ND = (B_W + 1) / 2;
	localparam int BP = 2 * ND;
	localparam int CW = $clog2(ND + 1);

	logic [A_W-1:0]    a1_q;
	logic [A_W+1:0]    a3_q;
	logic [A_W+BP-1:0] acc_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [A_W+1:0]    addend;
	logic [A_W+1:0]    sum;

	always_comb begin
		case (acc_q[1:0])
			2'd0: addend = '0;
			2'd1: addend = {2'b00, a1_q};
			2'd2: addend = {1'b0, a1_q, 1'b0};
			2'd3: addend = a3_q;
			default: addend = '0;
		endcase
	end

	assign sum = {2'b00, acc_q[A_W+BP-1:BP]} + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ND);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a1_q  <= a;
			a3_q  <= {2'b00, a} + {1'b0, a, 1'b0};
			acc_q <= {{A_W{1'b0}}, BP'(b)};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[BP-1:2]};
		end
	end

	assign busy = busy_q;
	assign p    = acc_q[A_W+B_W-1:0];

endmodule

// ===== sv/rgrls_serial_div.sv =====
// Restoring divider giving num/den in Q8.8, one quotient bit per cycle, saturated to 256.0.
module rgrls_serial_div
	import rgrls_pkg::*;
#(
	parameter int W = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   num,
	input  logic [W-1:0]   den,
	output logic           busy,
	output logic [EST_W:0] quo
);

	localparam int SH = EST_W - FRAC_W;
	localparam int CW = $clog2(EST_W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     den_q;
	logic [EST_W-1:0] low_q;
	logic [EST_W-1:0] q_q;
	logic             sat_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             sat_w;
	logic [W:0]       trial;
	logic [W+1:0]     diff_w;
	logic             ge;

	// quotient of 256.0 or more when num >= den * 2^8
	assign sat_w  = {{FRAC_W{1'b0}}, num} >= {den, {FRAC_W{1'b0}}};
	assign trial  = {rem_q, low_q[EST_W-1]};
	assign diff_w = {1'b0, trial} - {2'b00, den_q};
	assign ge     = !diff_w[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat_w;
			cnt_q  <= CW'(EST_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			sat_q <= sat_w;
			rem_q <= num >> SH;
			low_q <= {num[SH-1:0], {FRAC_W{1'b0}}};
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff_w[W-1:0] : trial[W-1:0];
			low_q <= {low_q[EST_W-2:0], 1'b0};
			q_q   <= {q_q[EST_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = sat_q ? {1'b1, {EST_W{1'b0}}} : {1'b0, q_q};

endmodule
